[sv/rlp_pkg.sv]
// Shared constants, types and the helper function of the RTP L16 packetizer.
`timescale 1ns / 1ps

package rlp_pkg;

    localparam logic [15:0] HDR_BASE  = 16'h8000;
    localparam logic [15:0] HDR_BYTES = 16'd12;

    // register reset values
    localparam logic [15:0] RST_MTU      = 16'd1460;
    localparam logic [1:0]  RST_CHANNELS = 2'd2;
    localparam logic [6:0]  RST_PT       = 7'd96;
    localparam logic        RST_LE       = 1'b1;
    localparam logic [31:0] RST_SSRC     = 32'd0;
    localparam logic [15:0] RST_SEQ      = 16'd0;
    localparam logic [31:0] RST_TS       = 32'd0;

    // configuration register indexes
    localparam logic [2:0] CFG_MTU      = 3'd0;
    localparam logic [2:0] CFG_CHANNELS = 3'd1;
    localparam logic [2:0] CFG_PT       = 3'd2;
    localparam logic [2:0] CFG_LE       = 3'd3;
    localparam logic [2:0] CFG_SSRC     = 3'd4;
    localparam logic [2:0] CFG_SEQ      = 3'd5;
    localparam logic [2:0] CFG_TS       = 3'd6;

    // request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DISC   = 1'b1;

    // output word selects, header words in wire order then the payload word
    localparam logic [2:0] SEL_PT      = 3'd0;
    localparam logic [2:0] SEL_SEQ     = 3'd1;
    localparam logic [2:0] SEL_TS_HI   = 3'd2;
    localparam logic [2:0] SEL_TS_LO   = 3'd3;
    localparam logic [2:0] SEL_SSRC_HI = 3'd4;
    localparam logic [2:0] SEL_SSRC_LO = 3'd5;
    localparam logic [2:0] SEL_PAYLOAD = 3'd6;

    typedef struct packed {
        logic        need_hdr;
        logic        closing;
        logic [15:0] word;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [6:0]  pt;
        logic [31:0] ssrc;
    } item_t;

    // payload word limit: whole frames that fit in mtu minus header, at least one frame
    function automatic logic [14:0] calc_limit(input logic [15:0] mtu, input logic stereo);
        logic [15:0] space;
        logic [14:0] lim;
        space = (mtu > HDR_BYTES) ? (mtu - HDR_BYTES) : 16'd0;
        if (stereo) begin
            lim = {space[15:2], 1'b0};
            if (lim == 15'd0) begin
                lim = 15'd2;
            end
        end else begin
            lim = space[15:1];
            if (lim == 15'd0) begin
                lim = 15'd1;
            end
        end
        return lim;
    endfunction

endpackage

[sv/rlp_front.sv]
// Input stage: configuration registers, packet state and the staged request.
`timescale 1ns / 1ps

module rlp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic                s_tlast,
    input  logic                s_tuser,
    input  logic                pop,
    output rlp_pkg::item_t      item,
    output logic                item_valid
);

    logic [15:0]     mtu_reg;
    logic [1:0]      ch_reg;
    logic [6:0]      pt_reg;
    logic            le_reg;
    logic [31:0]     ssrc_reg;
    logic [15:0]     seq_reg;
    logic [31:0]     ts_reg;
    logic            open_reg;
    logic [14:0]     pw_reg;
    logic [14:0]     limit_reg;
    logic            stage_valid_reg;
    logic            stage_valid_next;
    rlp_pkg::item_t  stage_reg;

    logic            accept;
    logic            stage_load;
    logic [14:0]     words;
    logic            closing;
    logic [15:0]     swapped;
    logic [14:0]     frames;
    logic [31:0]     ts_adv;
    rlp_pkg::item_t  new_item;

    assign s_tready   = !stage_valid_reg || pop;
    assign accept     = s_tvalid && s_tready;
    assign stage_load = accept && !cfg_we && (s_tuser == rlp_pkg::OP_SAMPLE);
    assign item       = stage_reg;
    assign item_valid = stage_valid_reg;

    always_comb begin
        words    = open_reg ? (pw_reg + 15'd1) : 15'd1;
        closing  = s_tlast || (words >= limit_reg);
        swapped  = le_reg ? {s_tdata[7:0], s_tdata[15:8]} : s_tdata;
        frames   = ch_reg[1] ? {1'b0, words[14:1]} : words;
        ts_adv   = ts_reg + {17'd0, frames};
        new_item = '{need_hdr: !open_reg, closing: closing, word: swapped,
                     seq: seq_reg, ts: ts_reg, pt: pt_reg, ssrc: ssrc_reg};
        stage_valid_next = (stage_valid_reg && !pop) || stage_load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg         <= rlp_pkg::RST_MTU;
            ch_reg          <= rlp_pkg::RST_CHANNELS;
            pt_reg          <= rlp_pkg::RST_PT;
            le_reg          <= rlp_pkg::RST_LE;
            ssrc_reg        <= rlp_pkg::RST_SSRC;
            seq_reg         <= rlp_pkg::RST_SEQ;
            ts_reg          <= rlp_pkg::RST_TS;
            open_reg        <= 1'b0;
            pw_reg          <= 15'd0;
            limit_reg       <= rlp_pkg::calc_limit(rlp_pkg::RST_MTU, rlp_pkg::RST_CHANNELS[1]);
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    rlp_pkg::CFG_MTU: begin
                        mtu_reg   <= cfg_data[15:0];
                        limit_reg <= rlp_pkg::calc_limit(cfg_data[15:0], ch_reg[1]);
                    end
                    rlp_pkg::CFG_CHANNELS: begin
                        ch_reg    <= cfg_data[1:0];
                        limit_reg <= rlp_pkg::calc_limit(mtu_reg, cfg_data[1]);
                    end
                    rlp_pkg::CFG_PT:   pt_reg   <= cfg_data[6:0];
                    rlp_pkg::CFG_LE:   le_reg   <= cfg_data[0];
                    rlp_pkg::CFG_SSRC: ssrc_reg <= cfg_data;
                    rlp_pkg::CFG_SEQ:  seq_reg  <= cfg_data[15:0];
                    rlp_pkg::CFG_TS:   ts_reg   <= cfg_data;
                    default: ;
                endcase
            end else if (accept) begin
                if (s_tuser == rlp_pkg::OP_DISC) begin
                    ts_reg <= 32'd0;
                end else begin
                    if (closing) begin
                        seq_reg  <= seq_reg + 16'd1;
                        ts_reg   <= ts_adv;
                        open_reg <= 1'b0;
                        pw_reg   <= 15'd0;
                    end else begin
                        open_reg <= 1'b1;
                        pw_reg   <= words;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load) begin
            stage_reg <= new_item;
        end
    end

endmodule

[sv/rlp_emit.sv]
// Output stage: header word sequencer and the result register.
`timescale 1ns / 1ps

module rlp_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  rlp_pkg::item_t      item,
    input  logic                item_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic [1:0]  m_tuser_reg;
    logic [2:0]  idx_reg;

    logic        load;
    logic [2:0]  sel;
    logic [15:0] word;

    assign load = !m_tvalid_reg || m_tready;
    assign sel  = item.need_hdr ? idx_reg : rlp_pkg::SEL_PAYLOAD;
    assign pop  = item_valid && load && (sel == rlp_pkg::SEL_PAYLOAD);

    always_comb begin
        case (sel)
            rlp_pkg::SEL_PT:      word = rlp_pkg::HDR_BASE | {9'd0, item.pt};
            rlp_pkg::SEL_SEQ:     word = item.seq;
            rlp_pkg::SEL_TS_HI:   word = item.ts[31:16];
            rlp_pkg::SEL_TS_LO:   word = item.ts[15:0];
            rlp_pkg::SEL_SSRC_HI: word = item.ssrc[31:16];
            rlp_pkg::SEL_SSRC_LO: word = item.ssrc[15:0];
            default:              word = item.word;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= 3'd0;
        end else if (load) begin
            m_tvalid_reg <= item_valid;
            if (item_valid) begin
                idx_reg <= pop ? 3'd0 : (idx_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && item_valid) begin
            m_tdata_reg <= word;
            m_tlast_reg <= (sel == rlp_pkg::SEL_PAYLOAD) && item.closing;
            m_tuser_reg <= {sel == rlp_pkg::SEL_PT, sel != rlp_pkg::SEL_PAYLOAD};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[sv/rtp_l16_audio_packetizer_core.sv]
// Top level of the RTP L16 audio packetizer.
`timescale 1ns / 1ps
//
// Sample words enter on the s_ stream, one request per 16-bit word; s_tuser
// high marks a discontinuity request, which zeroes the timestamp and emits
// nothing. s_tlast closes the packet after that word. Packets leave on the
// m_ stream as 16-bit wire-order words: six header words, then payload words;
// m_tlast marks the final payload word of a packet.
// A request is staged in the stage register when it is accepted; its first
// word then passes into the output register. Throughput: one payload word per
// cycle while m_tready is high; a request that opens a packet waits in the
// stage while the header sequencer that shares the output register runs.
// A stalled receiver holds the output register; one more request is taken
// into the stage register, then s_tready drops until the stage drains.
// Reset loads the register defaults (mtu 1460, stereo, payload type 96,
// little-endian input) and leaves no packet open. Configuration writes on
// cfg_we take effect at once and belong to idle periods only.
//

module rtp_l16_audio_packetizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // sample_word
    input  logic        s_tlast,
    input  logic        s_tuser,    // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_word
    output logic        m_tlast,
    output logic [1:0]  m_tuser     // [0] header_word, [1] packet_start
);

    rlp_pkg::item_t item;
    logic           item_valid;
    logic           pop;

    rlp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .pop        (pop),
        .item       (item),
        .item_valid (item_valid)
    );

    rlp_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .item_valid (item_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
